[rtl/txt2int_pkg.sv]
`default_nettype none

package txt2int_pkg;

  // largest base the alphabet can express
  localparam int MAX_RADIX = 16;

  localparam int CHAR_W      = 8;
  localparam int WORD_W      = 64;
  localparam int ALPHA_W     = 2 * WORD_W;
  localparam int RADIX_LEN_W = 5;
  localparam int DIGIT_W     = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int ACC_W       = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LEN  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0b;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0c;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

  localparam logic [RADIX_LEN_W-1:0] MIN_RADIX = 5'd2;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGIT  = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

`default_nettype wire

[rtl/text_to_integer_any_base.sv]
// channel   | dir | tdata bits (low first)                    | tuser / tlast
// ----------+-----+-------------------------------------------+--------------
// s_axis    | in  | char_in[7:0]                              | none
// m_axis    | out | parsed_value[31:0], radix_invalid[32], 0s | none
// cfg       | in  | cfg_index 0 chars 0..7, 1 chars 8..15, 2 length
//
// one character per cycle sustained unless a zero byte waits on the output
// register; a request is taken into an input register and parsed from there
// against the accumulator loop (32x5 multiply plus add), which is combinational
// a zero byte writes its result into the output register; while that
// register is still held by the sink, a zero byte waits in the input
// register and holds s_tready low; other bytes never wait on the output
// synchronous active-high reset clears parse state, config and valids;
// validity of the alphabet is registered in radix_bad from the config registers
`default_nettype none

module text_to_integer_any_base
  import txt2int_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // config write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [WORD_W-1:0]        cfg_data,
  // input characters
  input  wire logic                     s_tvalid,
  output      logic                     s_tready,
  input  wire logic [IN_TDATA_W-1:0]    s_tdata,   // char_in[7:0]
  // results
  output      logic                     m_tvalid,
  input  wire logic                     m_tready,
  output      logic [OUT_TDATA_W-1:0]   m_tdata    // parsed_value[31:0], radix_invalid[32]
);

  // configuration registers
  logic [WORD_W-1:0]      chars_low;
  logic [WORD_W-1:0]      chars_high;
  logic [RADIX_LEN_W-1:0] radix_len;
  logic                   radix_bad;
  logic                   radix_bad_next;

  // input register
  logic                   in_valid;
  logic [CHAR_W-1:0]      in_char;

  // parse state
  phase_t                 phase;
  phase_t                 phase_next;
  logic                   minus;
  logic                   minus_next;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       acc_next;

  // output register
  logic [ACC_W-1:0]       out_value;
  logic                   out_bad;

  logic [ALPHA_W-1:0]     alpha;
  logic [RADIX_LEN_W-1:0] used_len;
  logic                   digit_hit;
  logic [DIGIT_W-1:0]     digit;
  logic [ACC_W+RADIX_LEN_W-1:0] prod;
  logic                   out_free;
  logic                   in_advance;
  logic                   in_term;
  logic [ACC_W-1:0]       signed_acc;

  assign alpha    = {chars_high, chars_low};
  assign used_len = (radix_len > RADIX_LEN_W'(MAX_RADIX)) ? RADIX_LEN_W'(MAX_RADIX)
                                                         : radix_len;

  // handshake: a terminator needs the output register, other bytes do not
  assign out_free   = !m_tvalid || m_tready;
  assign in_term    = (in_char == CH_NUL);
  assign in_advance = in_valid && (!in_term || out_free);
  assign s_tready   = !in_valid || in_advance;

  // alphabet check over the registered config
  always_comb begin
    radix_bad_next = (radix_len < MIN_RADIX) || (radix_len > RADIX_LEN_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_LEN_W'(i) < radix_len) begin
        if (alpha[i*CHAR_W +: CHAR_W] == CH_NUL || is_sign(alpha[i*CHAR_W +: CHAR_W]) ||
            is_space(alpha[i*CHAR_W +: CHAR_W])) begin
          radix_bad_next = 1'b1;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_LEN_W'(j) < radix_len &&
              alpha[j*CHAR_W +: CHAR_W] == alpha[i*CHAR_W +: CHAR_W]) begin
            radix_bad_next = 1'b1;
          end
        end
      end
    end
  end

  // digit lookup, lowest matching entry wins
  always_comb begin
    digit_hit = 1'b0;
    digit     = '0;
    for (int k = MAX_RADIX - 1; k >= 0; k--) begin
      if (RADIX_LEN_W'(k) < used_len && alpha[k*CHAR_W +: CHAR_W] == in_char) begin
        digit_hit = 1'b1;
        digit     = DIGIT_W'(k);
      end
    end
  end

  assign prod = {{RADIX_LEN_W{1'b0}}, acc} * {{ACC_W{1'b0}}, used_len};

  // next parse state for a non-zero byte
  always_comb begin
    phase_next = phase;
    minus_next = minus;
    acc_next   = acc;
    if (phase == PH_SPACE && is_space(in_char)) begin
      phase_next = PH_SPACE;
    end else if ((phase == PH_SPACE || phase == PH_SIGN) && is_sign(in_char)) begin
      phase_next = PH_SIGN;
      minus_next = minus ^ (in_char == CH_MINUS);
    end else if (phase != PH_IGNORE) begin
      if (digit_hit) begin
        phase_next = PH_DIGIT;
        acc_next   = prod[ACC_W-1:0] + {{(ACC_W-DIGIT_W){1'b0}}, digit};
      end else begin
        phase_next = PH_IGNORE;
      end
    end
  end

  assign signed_acc = minus ? (ACC_W'(0) - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low  <= '0;
      chars_high <= '0;
      radix_len  <= '0;
      radix_bad  <= 1'b1;
      in_valid   <= 1'b0;
      phase      <= PH_SPACE;
      minus      <= 1'b0;
      acc        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHARS_LOW:  chars_low  <= cfg_data;
          REG_CHARS_HIGH: chars_high <= cfg_data;
          REG_RADIX_LEN:  radix_len  <= cfg_data[RADIX_LEN_W-1:0];
          default: ;
        endcase
      end
      radix_bad <= radix_bad_next;

      if (s_tready) begin
        in_valid <= s_tvalid;
      end

      if (in_advance) begin
        if (in_term) begin
          phase <= PH_SPACE;
          minus <= 1'b0;
          acc   <= '0;
        end else begin
          phase <= phase_next;
          minus <= minus_next;
          acc   <= acc_next;
        end
      end

      if (in_advance && in_term) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata[CHAR_W-1:0];
    end
    if (in_advance && in_term) begin
      out_value <= radix_bad ? '0 : signed_acc;
      out_bad   <= radix_bad;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-ACC_W-1){1'b0}}, out_bad, out_value};

  // a bad alphabet always yields zero
  a_bad_gives_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_bad |-> out_value == '0)
    else $error("invalid alphabet produced a nonzero value");

  // a terminator returns the parser to its reset state
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    in_advance && in_term |=> phase == PH_SPACE && !minus && acc == '0)
    else $error("parse state not cleared after terminator");

  // once ignoring, the accumulator is frozen until the terminator
  a_ignore_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IGNORE && !(in_advance && in_term) |=> $stable(acc) && phase == PH_IGNORE)
    else $error("accumulator moved while ignoring");

  // a terminator blocked by a full output register waits in place
  a_term_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_term && !out_free |=> in_valid && in_term && m_tvalid)
    else $error("blocked terminator lost");

endmodule

`default_nettype wire
